// ===== src/hsfcw_pkg.sv =====
package hsfcw_pkg;

    localparam int CMD_W    = 3;
    localparam int AMT_W    = 32;
    localparam int CREDIT_W = 31;
    localparam int STATUS_W = 2;
    localparam int OP_W     = 3;

    // Default depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [AMT_W-1:0]    t_amount;
    typedef logic [CREDIT_W-1:0] t_credit;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [OP_W-1:0]     t_op;

    // Command codes on the input channel.
    localparam t_cmd CMD_INIT      = 3'd0;
    localparam t_cmd CMD_TAKE_SEND = 3'd1;
    localparam t_cmd CMD_TAKE_RECV = 3'd2;
    localparam t_cmd CMD_ADD_SEND  = 3'd3;
    localparam t_cmd CMD_ADD_RECV  = 3'd4;
    localparam t_cmd CMD_UPDATE    = 3'd5;

    // Status codes on the result channel.
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_SHORT = 2'd1;
    localparam t_status ST_PROTO = 2'd2;
    localparam t_status ST_FLOW  = 2'd3;

    // Operations after classification. The last two only report a status.
    localparam t_op OP_INIT      = 3'd0;
    localparam t_op OP_TAKE_SEND = 3'd1;
    localparam t_op OP_TAKE_RECV = 3'd2;
    localparam t_op OP_ADD_SEND  = 3'd3;
    localparam t_op OP_ADD_RECV  = 3'd4;
    localparam t_op OP_UPDATE    = 3'd5;
    localparam t_op OP_PROTO     = 3'd6;
    localparam t_op OP_FLOW      = 3'd7;

    typedef struct packed {
        t_op     op;
        t_amount amount;
    } t_item;

endpackage

// ===== src/hsfcw_if.sv =====
interface hsfcw_cmd_if;
    logic                 valid;
    logic                 ready;
    hsfcw_pkg::t_cmd      cmd;
    hsfcw_pkg::t_amount   amount;

    modport source (output valid, output cmd, output amount, input ready);
    modport sink   (input valid, input cmd, input amount, output ready);
endinterface

interface hsfcw_res_if;
    logic                 valid;
    logic                 ready;
    hsfcw_pkg::t_status   status;
    hsfcw_pkg::t_credit   send_credit;
    hsfcw_pkg::t_credit   recv_credit;

    modport source (output valid, output status, output send_credit, output recv_credit,
                    input ready);
    modport sink   (input valid, input status, input send_credit, input recv_credit,
                    output ready);
endinterface

// ===== src/hsfcw_front.sv =====
module hsfcw_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    hsfcw_cmd_if.sink           i_cmd_ch,
    output logic                o_valid,
    output hsfcw_pkg::t_item    o_item,
    input  logic                i_ready
);

    logic             r_valid;
    hsfcw_pkg::t_item r_item;
    hsfcw_pkg::t_item n_item;
    logic             w_accept;

    assign i_cmd_ch.ready = !r_valid || i_ready;
    assign w_accept       = i_cmd_ch.valid && i_cmd_ch.ready;

    // Work out everything that does not depend on the credits, so the back
    // only has to do the arithmetic.
    always_comb begin
        n_item.amount = i_cmd_ch.amount;
        case (i_cmd_ch.cmd)
            hsfcw_pkg::CMD_INIT: begin
                n_item.op = i_cmd_ch.amount[hsfcw_pkg::AMT_W-1] ?
                            hsfcw_pkg::OP_FLOW : hsfcw_pkg::OP_INIT;
            end
            hsfcw_pkg::CMD_TAKE_SEND: n_item.op = hsfcw_pkg::OP_TAKE_SEND;
            hsfcw_pkg::CMD_TAKE_RECV: n_item.op = hsfcw_pkg::OP_TAKE_RECV;
            hsfcw_pkg::CMD_ADD_SEND: begin
                n_item.op = (i_cmd_ch.amount == '0) ?
                            hsfcw_pkg::OP_PROTO : hsfcw_pkg::OP_ADD_SEND;
            end
            hsfcw_pkg::CMD_ADD_RECV:  n_item.op = hsfcw_pkg::OP_ADD_RECV;
            hsfcw_pkg::CMD_UPDATE:    n_item.op = hsfcw_pkg::OP_UPDATE;
            default:                  n_item.op = hsfcw_pkg::OP_PROTO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== src/hsfcw_queue.sv =====
module hsfcw_queue #(
    parameter int DEPTH = hsfcw_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  hsfcw_pkg::t_item    i_item,
    output logic                o_ready,
    output logic                o_valid,
    output hsfcw_pkg::t_item    o_item,
    input  logic                i_ready
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    hsfcw_pkg::t_item r_slot [DEPTH];
    hsfcw_pkg::t_item n_slot [DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] w_wr_idx;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[0];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // The head always sits in slot zero; a pop shifts the rest down.
    assign w_wr_idx = r_count - CNT_W'(w_pop);

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            if (w_pop && (i < DEPTH - 1)) begin
                n_slot[i] = r_slot[(i < DEPTH - 1) ? i + 1 : i];
            end else begin
                n_slot[i] = r_slot[i];
            end
            if (w_push && (w_wr_idx == CNT_W'(i))) begin
                n_slot[i] = i_item;
            end
        end
        n_count = r_count + CNT_W'(w_push) - CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

endmodule

// ===== src/hsfcw_back.sv =====
module hsfcw_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  hsfcw_pkg::t_item    i_item,
    output logic                o_ready,
    hsfcw_res_if.source         o_res_ch
);

    localparam int CW = hsfcw_pkg::CREDIT_W;
    localparam int AW = hsfcw_pkg::AMT_W;

    hsfcw_pkg::t_credit r_send;
    hsfcw_pkg::t_credit r_recv;
    hsfcw_pkg::t_amount r_init;
    hsfcw_pkg::t_credit n_send;
    hsfcw_pkg::t_credit n_recv;
    hsfcw_pkg::t_amount n_init;
    hsfcw_pkg::t_status n_status;

    logic               r_out_valid;
    hsfcw_pkg::t_status r_status;
    hsfcw_pkg::t_credit r_out_send;
    hsfcw_pkg::t_credit r_out_recv;

    logic               w_pop;
    hsfcw_pkg::t_credit w_take_src;
    hsfcw_pkg::t_credit w_add_src;
    logic               w_short;
    logic [AW:0]        w_sum;
    logic [AW+1:0]      w_upd;

    assign o_ready = !r_out_valid || o_res_ch.ready;
    assign w_pop   = i_valid && o_ready;

    assign w_take_src = (i_item.op == hsfcw_pkg::OP_TAKE_SEND) ? r_send : r_recv;
    assign w_add_src  = (i_item.op == hsfcw_pkg::OP_ADD_SEND)  ? r_send : r_recv;
    assign w_short    = i_item.amount > {1'b0, w_take_src};
    assign w_sum      = {2'b00, w_add_src} + {1'b0, i_item.amount};
    // Signed difference: send + new initial - old initial.
    assign w_upd      = {3'b000, r_send} + {2'b00, i_item.amount} - {2'b00, r_init};

    always_comb begin
        n_send   = r_send;
        n_recv   = r_recv;
        n_init   = r_init;
        n_status = hsfcw_pkg::ST_OK;
        case (i_item.op)
            hsfcw_pkg::OP_INIT: begin
                n_send = i_item.amount[CW-1:0];
                n_recv = i_item.amount[CW-1:0];
                n_init = i_item.amount;
            end
            hsfcw_pkg::OP_TAKE_SEND, hsfcw_pkg::OP_TAKE_RECV: begin
                if (w_short) begin
                    n_status = hsfcw_pkg::ST_SHORT;
                end else if (i_item.op == hsfcw_pkg::OP_TAKE_SEND) begin
                    n_send = w_take_src - i_item.amount[CW-1:0];
                end else begin
                    n_recv = w_take_src - i_item.amount[CW-1:0];
                end
            end
            hsfcw_pkg::OP_ADD_SEND, hsfcw_pkg::OP_ADD_RECV: begin
                if (w_sum[AW:CW] != '0) begin
                    n_status = hsfcw_pkg::ST_FLOW;
                end else if (i_item.op == hsfcw_pkg::OP_ADD_SEND) begin
                    n_send = w_sum[CW-1:0];
                end else begin
                    n_recv = w_sum[CW-1:0];
                end
            end
            hsfcw_pkg::OP_UPDATE: begin
                if (w_upd[AW+1:CW] != '0) begin
                    n_status = hsfcw_pkg::ST_FLOW;
                end else begin
                    n_send = w_upd[CW-1:0];
                    n_init = i_item.amount;
                end
            end
            hsfcw_pkg::OP_PROTO: n_status = hsfcw_pkg::ST_PROTO;
            default:             n_status = hsfcw_pkg::ST_FLOW;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_send      <= '0;
            r_recv      <= '0;
            r_init      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_pop) begin
                r_send <= n_send;
                r_recv <= n_recv;
                r_init <= n_init;
            end
            if (w_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_status   <= n_status;
            r_out_send <= n_send;
            r_out_recv <= n_recv;
        end
    end

    assign o_res_ch.valid       = r_out_valid;
    assign o_res_ch.status      = r_status;
    assign o_res_ch.send_credit = r_out_send;
    assign o_res_ch.recv_credit = r_out_recv;

endmodule

// ===== src/http2_stream_flow_control_windows.sv =====
// Flow-control credit keeper for one HTTP/2 stream: send window, receive window
// and the initial send window size last applied.
// Commands arrive on i_cmd_ch (cmd, amount) and each one yields exactly one item
// on o_res_ch: a status code and both windows as they stand after the command.
// Both channels use valid/ready; an item moves when both are high at a clock edge.
// A command passes through the front register, a queue slot and the result
// register before its result is valid on o_res_ch.
// The block takes one item per cycle while o_res_ch is not stalled: the front
// register, the queue and the credit update in the back each take one item per
// cycle, and the update of one command is plain add/subtract arithmetic with a
// compare, so the next command sees the new windows in the following cycle.
// Reset (i_rst_n low at a clock edge) clears both windows, the initial value,
// the queue and the result valid flag; the block takes commands right after it.
// When the receiver stalls, the result waits in the output register, the back
// stops, the queue fills, and only then does i_cmd_ch.ready fall.
module http2_stream_flow_control_windows #(
    parameter int QUEUE_DEPTH = hsfcw_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hsfcw_cmd_if.sink   i_cmd_ch,
    hsfcw_res_if.source o_res_ch
);

    // Front to queue.
    logic             w_fq_valid;
    logic             w_fq_ready;
    hsfcw_pkg::t_item w_fq_item;

    // Queue to back.
    logic             w_qb_valid;
    logic             w_qb_ready;
    hsfcw_pkg::t_item w_qb_item;

    // The front decodes each command and settles the cases that need no credit
    // (oversized init, zero send increment, unknown command).
    hsfcw_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_ch (i_cmd_ch),
        .o_valid  (w_fq_valid),
        .o_item   (w_fq_item),
        .i_ready  (w_fq_ready)
    );

    // A short queue lets the front keep taking commands while the back waits.
    hsfcw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fq_valid),
        .i_item  (w_fq_item),
        .o_ready (w_fq_ready),
        .o_valid (w_qb_valid),
        .o_item  (w_qb_item),
        .i_ready (w_qb_ready)
    );

    // The back holds the windows, applies each command and registers the result.
    hsfcw_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_qb_valid),
        .i_item   (w_qb_item),
        .o_ready  (w_qb_ready),
        .o_res_ch (o_res_ch)
    );

endmodule
